// ===== hw/rtl/radix2_complex_fft_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the radix-2 FFT block
// Shared wrappers for concurrent checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef RADIX2_COMPLEX_FFT_ASSERT_SVH
`define RADIX2_COMPLEX_FFT_ASSERT_SVH

// Same-cycle implication under an active-low reset.
`define R2FFT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under an active-low reset.
`define R2FFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/r2fft_pkg.sv =====
// ----------------------------------------------------------------------------
// r2fft_pkg
// Types, register indexes and the quarter-wave cosine table of the FFT.
// ----------------------------------------------------------------------------
package r2fft_pkg;

  localparam int unsigned StoreBits = 22;
  localparam int unsigned IndexBits = 6;
  localparam int unsigned TableBits = 24;
  localparam int unsigned CfgIdxBits = 1;
  localparam int unsigned CfgDataBits = 3;

  localparam logic [CfgIdxBits-1:0] CFG_INVERSE = 1'b0;
  localparam logic [CfgIdxBits-1:0] CFG_LOG2_POINTS = 1'b1;

  typedef logic signed [StoreBits-1:0] store_t;
  // One bit above the Q1.23 range so that a cosine of exactly one stays positive.
  typedef logic signed [TableBits:0] table_t;

  // Cosine of 2*pi*k/64 for k = 0..16, Q1.23.
  localparam table_t QuarterCos [17] = '{
    25'sd8388608, 25'sd8348215, 25'sd8227423, 25'sd8027397, 25'sd7750063,
    25'sd7398092, 25'sd6974873, 25'sd6484482, 25'sd5931642, 25'sd5321677,
    25'sd4660461, 25'sd3954362, 25'sd3210181, 25'sd2435084, 25'sd1636536,
    25'sd822227, 25'sd0
  };

  typedef enum logic [11:0] {
    ST_LOAD = 12'b000000000001,
    ST_RA   = 12'b000000000010,
    ST_RB   = 12'b000000000100,
    ST_M0   = 12'b000000001000,
    ST_M1   = 12'b000000010000,
    ST_M2   = 12'b000000100000,
    ST_M3   = 12'b000001000000,
    ST_M4   = 12'b000010000000,
    ST_M5   = 12'b000100000000,
    ST_W0   = 12'b001000000000,
    ST_W1   = 12'b010000000000,
    ST_EMIT = 12'b100000000000
  } state_e;

endpackage

// ===== hw/rtl/r2fft_ram.sv =====
// ----------------------------------------------------------------------------
// r2fft_ram
// Generic one-write, one-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module r2fft_ram #(
  parameter int unsigned Width = 44,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/radix2_complex_fft.sv =====
// ----------------------------------------------------------------------------
// radix2_complex_fft
// In-place radix-2 decimation-in-time complex FFT with one shared multiplier.
// ----------------------------------------------------------------------------
// A frame of 2^log2_points samples is loaded one sample per start transfer,
// written straight to its bit-reversed address. busy rises after the last
// sample; the butterflies then run through one multiplier, each butterfly
// taking two reads on the read port, four products and two writes on the
// write port, and busy stays high so that no new frame is taken until
// every bin has been emitted. Every bin is presented in index order, one
// per cycle on bin_valid_o, with last_bin_o on the final one.
// The receiver cannot stall; each bin is valid for exactly one cycle.
`include "radix2_complex_fft_assert.svh"

module radix2_complex_fft #(
  parameter int unsigned MAX_POINTS   = 64,
  parameter int unsigned SAMPLE_BITS  = 16,
  parameter int unsigned TWIDDLE_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [r2fft_pkg::CfgIdxBits-1:0]       cfg_index_i,
  input  logic [r2fft_pkg::CfgDataBits-1:0]      cfg_data_i,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [SAMPLE_BITS-1:0]          sample_real_i,
  input  logic signed [SAMPLE_BITS-1:0]          sample_imag_i,
  output logic                                   bin_valid_o,
  output logic signed [r2fft_pkg::StoreBits-1:0] bin_real_o,
  output logic signed [r2fft_pkg::StoreBits-1:0] bin_imag_o,
  output logic [r2fft_pkg::IndexBits-1:0]        bin_index_o,
  output logic                                   last_bin_o
);

  import r2fft_pkg::*;

  localparam int unsigned MaxLg = $clog2(MAX_POINTS + 1) - 1;
  localparam int unsigned Aw = MaxLg;
  localparam int unsigned Depth = 1 << Aw;
  localparam int unsigned Tw = TWIDDLE_BITS;
  localparam int unsigned TwSh = TableBits - Tw;
  localparam int unsigned Pw = StoreBits + Tw;
  localparam int unsigned Tt = Pw + 2 - Tw;
  localparam int unsigned Sw = Tt + 1;
  localparam int unsigned Xw = (SAMPLE_BITS > StoreBits) ? SAMPLE_BITS : StoreBits;

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [Tw-1:0] reduce_tw(input table_t v);
    logic [TableBits:0] mag;
    logic [TableBits:0] half;
    logic [TableBits:0] r;
    logic [TableBits:0] lim;
    mag  = v[TableBits] ? (TableBits+1)'(-v) : (TableBits+1)'(v);
    half = (TwSh == 0) ? '0 : ((TableBits+1)'(1) << (TwSh - 1));
    lim  = ((TableBits+1)'(1) << (Tw - 1)) - 1'b1;
    r    = (mag + half) >> TwSh;
    if (r > lim) begin
      r = lim;
    end
    return v[TableBits] ? -Tw'(r) : Tw'(r);
  endfunction

  function automatic store_t sat_sum(input logic signed [Sw-1:0] v);
    logic signed [Sw-1:0] hi;
    logic signed [Sw-1:0] lo;
    hi = Sw'((64'sd1 <<< (StoreBits - 1)) - 1);
    lo = -Sw'(64'sd1 <<< (StoreBits - 1));
    if (v > hi) return store_t'(hi);
    if (v < lo) return store_t'(lo);
    return store_t'(v);
  endfunction

  function automatic store_t sat_in(input logic signed [SAMPLE_BITS-1:0] v);
    logic signed [Xw:0] x;
    logic signed [Xw:0] hi;
    logic signed [Xw:0] lo;
    x  = (Xw+1)'(v);
    hi = (Xw+1)'((64'sd1 <<< (StoreBits - 1)) - 1);
    lo = -(Xw+1)'(64'sd1 <<< (StoreBits - 1));
    if (x > hi) return store_t'(hi);
    if (x < lo) return store_t'(lo);
    return store_t'(x);
  endfunction

  function automatic logic signed [Tt-1:0] rnd_prod(input logic signed [Pw:0] v);
    logic signed [Pw:0] s;
    s = (v + ((Pw+1)'(1) << (Tw - 2))) >>> (Tw - 1);
    return Tt'(s);
  endfunction

  function automatic store_t rnd_shift(input store_t v, input logic [2:0] sh);
    logic signed [StoreBits:0] x;
    x = (StoreBits+1)'(v) + ((StoreBits+1)'(1) << (sh - 3'd1));
    return store_t'(x >>> sh);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic       inverse_q;
  logic [2:0] log2_points_q;
  logic [2:0] lg;
  logic [Aw:0] n_pts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inverse_q     <= 1'b0;
      log2_points_q <= 3'd6;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_INVERSE:     inverse_q     <= cfg_data_i[0];
        CFG_LOG2_POINTS: log2_points_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    lg = log2_points_q;
    if (lg == 3'd0) lg = 3'd1;
    if (lg == 3'd7) lg = 3'd6;
    if (lg > 3'(MaxLg)) lg = 3'(MaxLg);
  end

  assign n_pts = (Aw+1)'(1) << lg;

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;
  logic [Aw:0]   load_q;
  logic [2:0]    stage_q;
  logic [Aw-1:0] i_q;
  logic [Aw-1:0] j_q;
  logic [Aw-1:0] k_q;
  logic [Aw:0]   l1;
  logic [Aw:0]   l2;
  logic [Aw-1:0] i1;
  logic          accept;

  assign busy   = (state_q != ST_LOAD);
  assign accept = start && !busy && !cfg_we_i;
  assign l1     = (Aw+1)'(1) << (stage_q - 3'd1);
  assign l2     = (Aw+1)'(1) << stage_q;
  assign i1     = i_q | l1[Aw-1:0];

  // Load address: bit reversal of the sample count over lg bits.
  logic [Aw-1:0] rev_full;
  logic [Aw-1:0] load_addr;
  always_comb begin
    for (int b = 0; b < Aw; b++) begin
      rev_full[b] = load_q[Aw-1-b];
    end
  end
  assign load_addr = rev_full >> (3'(Aw) - lg);

  // ---------------------------------------------------------------------------
  // Twiddle for the current stage and group
  // ---------------------------------------------------------------------------
  logic [5:0] tw_k6;
  logic [4:0] tw_k;
  logic signed [Tw-1:0] tw_c;
  logic signed [Tw-1:0] tw_s;
  logic signed [Tw-1:0] wr_q;
  logic signed [Tw-1:0] wi_q;

  assign tw_k6 = 6'(j_q) << (3'd6 - stage_q);
  assign tw_k  = tw_k6[4:0];

  always_comb begin
    if (tw_k <= 5'd16) begin
      tw_c = reduce_tw(QuarterCos[tw_k]);
      tw_s = reduce_tw(QuarterCos[5'd16 - tw_k]);
    end else begin
      tw_c = -reduce_tw(QuarterCos[5'd0 - tw_k]);
      tw_s = reduce_tw(QuarterCos[tw_k - 5'd16]);
    end
  end

  // ---------------------------------------------------------------------------
  // Memory
  // ---------------------------------------------------------------------------
  logic                      ram_we;
  logic [Aw-1:0]             ram_waddr;
  logic [2*StoreBits-1:0]    ram_wdata;
  logic [Aw-1:0]             ram_raddr;
  logic [2*StoreBits-1:0]    ram_rdata;
  store_t                    rd_re;
  store_t                    rd_im;

  assign rd_re = store_t'(ram_rdata[2*StoreBits-1:StoreBits]);
  assign rd_im = store_t'(ram_rdata[StoreBits-1:0]);

  r2fft_ram #(
    .Width (2 * StoreBits),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Shared multiplier and butterfly adder
  // ---------------------------------------------------------------------------
  store_t ar_q, ai_q, br_q, bi_q;
  logic signed [Tw-1:0]  op_w;
  store_t                op_x;
  logic signed [Pw-1:0]  prod_q;
  logic signed [Pw-1:0]  acc_q;
  logic signed [Tt-1:0]  tr_q, ti_q;
  logic signed [Sw-1:0]  sum_re, sum_im;
  logic                  sub;

  always_comb begin
    op_w = wr_q;
    op_x = br_q;
    case (state_q)
      ST_M2:   begin op_w = wi_q; op_x = bi_q; end
      ST_M3:   begin op_w = wr_q; op_x = bi_q; end
      ST_M4:   begin op_w = wi_q; op_x = br_q; end
      default: begin op_w = wr_q; op_x = br_q; end
    endcase
  end

  assign sub    = (state_q == ST_W1);
  assign sum_re = sub ? Sw'(ar_q) - Sw'(tr_q) : Sw'(ar_q) + Sw'(tr_q);
  assign sum_im = sub ? Sw'(ai_q) - Sw'(ti_q) : Sw'(ai_q) + Sw'(ti_q);

  always_ff @(posedge clk_i) begin
    prod_q <= Pw'(op_w * op_x);
    case (state_q)
      ST_RA: begin
        wr_q <= tw_c;
        wi_q <= inverse_q ? tw_s : -tw_s;
      end
      ST_RB: begin
        ar_q <= rd_re;
        ai_q <= rd_im;
      end
      ST_M0: begin
        br_q <= rd_re;
        bi_q <= rd_im;
      end
      ST_M2: acc_q <= prod_q;
      ST_M3: tr_q <= rnd_prod((Pw+1)'(acc_q) - (Pw+1)'(prod_q));
      ST_M4: acc_q <= prod_q;
      ST_M5: ti_q <= rnd_prod((Pw+1)'(acc_q) + (Pw+1)'(prod_q));
      default: ;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = load_addr;
    ram_wdata = {sat_in(sample_real_i), sat_in(sample_imag_i)};
    ram_raddr = i_q;
    case (state_q)
      ST_LOAD: ram_we = accept;
      ST_RB:   ram_raddr = i1;
      ST_W0: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = {sat_sum(sum_re), sat_sum(sum_im)};
      end
      ST_W1: begin
        ram_we    = 1'b1;
        ram_waddr = i1;
        ram_wdata = {sat_sum(sum_re), sat_sum(sum_im)};
      end
      ST_EMIT: ram_raddr = k_q;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic [Aw:0] i_next;
  logic [Aw:0] j_next;
  logic        emit_last;

  assign i_next    = (Aw+1)'(i_q) + l2;
  assign j_next    = (Aw+1)'(j_q) + 1'b1;
  assign emit_last = ((Aw+1)'(k_q) == n_pts - 1'b1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: if (accept && (load_q + 1'b1 == n_pts)) state_d = ST_RA;
      ST_RA:   state_d = ST_RB;
      ST_RB:   state_d = ST_M0;
      ST_M0:   state_d = ST_M1;
      ST_M1:   state_d = ST_M2;
      ST_M2:   state_d = ST_M3;
      ST_M3:   state_d = ST_M4;
      ST_M4:   state_d = ST_M5;
      ST_M5:   state_d = ST_W0;
      ST_W0:   state_d = ST_W1;
      ST_W1: begin
        if (i_next >= n_pts && j_next >= l1 && stage_q == lg) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_RA;
        end
      end
      ST_EMIT: if (emit_last) state_d = ST_LOAD;
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      load_q  <= '0;
      stage_q <= 3'd1;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_LOAD: begin
          if (cfg_we_i) begin
            load_q <= '0;
          end else if (accept) begin
            if (load_q + 1'b1 == n_pts) begin
              load_q  <= '0;
              stage_q <= 3'd1;
              i_q     <= '0;
              j_q     <= '0;
            end else begin
              load_q <= load_q + 1'b1;
            end
          end
        end
        ST_W1: begin
          if (i_next < n_pts) begin
            i_q <= i_next[Aw-1:0];
          end else if (j_next < l1) begin
            j_q <= j_next[Aw-1:0];
            i_q <= j_next[Aw-1:0];
          end else begin
            stage_q <= stage_q + 3'd1;
            j_q     <= '0;
            i_q     <= '0;
            k_q     <= '0;
          end
        end
        ST_EMIT: k_q <= emit_last ? '0 : k_q + 1'b1;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result port: the RAM read register carries the bin data.
  // ---------------------------------------------------------------------------
  logic          strobe_q;
  logic          last_q;
  logic [Aw-1:0] idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      strobe_q <= (state_q == ST_EMIT);
      last_q   <= (state_q == ST_EMIT) && emit_last;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= k_q;
  end

  assign bin_valid_o = strobe_q;
  assign last_bin_o  = last_q;
  assign bin_index_o = IndexBits'(idx_q);
  assign bin_real_o  = inverse_q ? rnd_shift(rd_re, lg) : rd_re;
  assign bin_imag_o  = inverse_q ? rnd_shift(rd_im, lg) : rd_im;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `R2FFT_ASSERT_NEXT(a_emit_strobe, clk_i, rst_ni, state_q == ST_EMIT, bin_valid_o,
                     "bin transfer missing after an emit cycle")
  `R2FFT_ASSERT_NOW(a_last_has_strobe, clk_i, rst_ni, last_bin_o, bin_valid_o,
                    "last_bin_o raised outside a bin transfer")
  `R2FFT_ASSERT_NOW(a_no_ram_clash, clk_i, rst_ni, busy && ram_we,
                    state_q == ST_W0 || state_q == ST_W1,
                    "RAM written by the sequencer outside a write-back cycle")

endmodule

// ===== bench/radix2_complex_fft_checker.sv =====
// ----------------------------------------------------------------------------
// radix2_complex_fft_checker
// Watches the configuration port, the sample transfers and the bin strobe of
// the FFT, keeps its own copy of the frame and the settings, computes every
// bin of a completed frame and compares each emitted bin with the oldest one
// still outstanding.
// ----------------------------------------------------------------------------
module radix2_complex_fft_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [r2fft_pkg::CfgIdxBits-1:0]       cfg_index_i,
  input  logic [r2fft_pkg::CfgDataBits-1:0]      cfg_data_i,
  input  logic                                   start_i,
  input  logic                                   busy_i,
  input  logic signed [15:0]                     sample_real_i,
  input  logic signed [15:0]                     sample_imag_i,
  input  logic                                   bin_valid_i,
  input  logic signed [r2fft_pkg::StoreBits-1:0] bin_real_i,
  input  logic signed [r2fft_pkg::StoreBits-1:0] bin_imag_i,
  input  logic [r2fft_pkg::IndexBits-1:0]        bin_index_i,
  input  logic                                   last_bin_i,
  output int                                     pending_o,
  output int                                     fails_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import r2fft_pkg::*;

  typedef struct {
    store_t                 re;
    store_t                 im;
    logic [IndexBits-1:0]   idx;
    logic                   last;
  } bin_t;

  bin_t   bins_due[$];
  longint frame_re [64];
  longint frame_im [64];
  int     loaded;
  logic   inv_mode;
  logic [2:0] lg_cfg;
  int     fail_count;

  assign fails_o = fail_count;

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t: bin mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic longint clamp22(input longint v);
    if (v > 2097151) return 2097151;
    if (v < -2097152) return -2097152;
    return v;
  endfunction

  // Half-up rounding: add half an LSB, then arithmetic shift.
  function automatic longint rshift_round(input longint v, input int sh);
    if (sh == 0) return v;
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint q15_of(input longint v);
    longint mag, r;
    mag = (v < 0) ? -v : v;
    r = (mag + 128) >>> 8;
    if (r > 32767) r = 32767;
    return (v < 0) ? -r : r;
  endfunction

  task automatic twiddle(input int k, output longint c, output longint s);
    k = k & 31;
    if (k <= 16) begin
      c = q15_of(QuarterCos[k]);
      s = q15_of(QuarterCos[16 - k]);
    end else begin
      c = q15_of(-longint'(QuarterCos[32 - k]));
      s = q15_of(QuarterCos[k - 16]);
    end
  endtask

  function automatic int points_log2();
    if (lg_cfg < 1) return 1;
    if (lg_cfg > 6) return 6;
    return lg_cfg;
  endfunction

  task automatic transform_frame(input int lg);
    int n, r, span, half;
    longint t, wr, ws, wi, xr, xi, tr, ti;
    bin_t b;
    n = 1 << lg;
    for (int i = 0; i < n; i++) begin
      r = 0;
      for (int k = 0; k < lg; k++) r |= ((i >> k) & 1) << (lg - 1 - k);
      if (i < r) begin
        t = frame_re[i]; frame_re[i] = frame_re[r]; frame_re[r] = t;
        t = frame_im[i]; frame_im[i] = frame_im[r]; frame_im[r] = t;
      end
    end
    for (span = 2; span <= n; span = span << 1) begin
      half = span >> 1;
      for (int j = 0; j < half; j++) begin
        twiddle(j * (64 / span), wr, ws);
        wi = inv_mode ? ws : -ws;
        for (int i = j; i + half < n; i += span) begin
          xr = frame_re[i + half];
          xi = frame_im[i + half];
          tr = rshift_round(wr * xr - wi * xi, 15);
          ti = rshift_round(wr * xi + wi * xr, 15);
          frame_re[i + half] = clamp22(frame_re[i] - tr);
          frame_im[i + half] = clamp22(frame_im[i] - ti);
          frame_re[i] = clamp22(frame_re[i] + tr);
          frame_im[i] = clamp22(frame_im[i] + ti);
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      if (inv_mode) begin
        frame_re[i] = rshift_round(frame_re[i], lg);
        frame_im[i] = rshift_round(frame_im[i], lg);
      end
      b.re = store_t'(frame_re[i]);
      b.im = store_t'(frame_im[i]);
      b.idx = i[IndexBits-1:0];
      b.last = (i == n - 1);
      bins_due.push_back(b);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bin_t want;
    if (!rst_ni) begin
      bins_due.delete();
      loaded = 0;
      inv_mode = 1'b0;
      lg_cfg = 3'd6;
      fail_count = 0;
    end else begin
      if (bin_valid_i) begin
        if (bins_due.size() == 0) begin
          $display("%0t: bin %0d emitted with none outstanding", $realtime, bin_index_i);
          fail_count++;
        end else begin
          want = bins_due.pop_front();
          if (bin_real_i !== want.re) report("real", bin_real_i, want.re);
          if (bin_imag_i !== want.im) report("imag", bin_imag_i, want.im);
          if (bin_index_i !== want.idx) report("index", bin_index_i, want.idx);
          if (last_bin_i !== want.last) report("last", last_bin_i, want.last);
        end
      end
      if (cfg_we_i) begin
        // Any register write throws away a partly loaded frame.
        if (cfg_index_i == CFG_INVERSE) inv_mode = cfg_data_i[0];
        else if (cfg_index_i == CFG_LOG2_POINTS) lg_cfg = cfg_data_i;
        loaded = 0;
      end
      if (start_i && !busy_i && !cfg_we_i) begin
        frame_re[loaded] = sample_real_i;
        frame_im[loaded] = sample_imag_i;
        loaded++;
        if (loaded >= (1 << points_log2())) begin
          loaded = 0;
          transform_frame(points_log2());
        end
      end
    end
    pending_o = bins_due.size();
  end

endmodule

// ===== bench/radix2_complex_fft_tb.sv =====
// ----------------------------------------------------------------------------
// radix2_complex_fft_tb
// Drives frames of complex samples into the FFT under changing transform
// direction and frame length, with random gaps between transfers, while the
// checker predicts and compares every bin.
// ----------------------------------------------------------------------------
module radix2_complex_fft_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import r2fft_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i = '0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] sample_real_i = '0;
  logic signed [15:0] sample_imag_i = '0;
  logic bin_valid_o;
  logic signed [StoreBits-1:0] bin_real_o, bin_imag_o;
  logic [IndexBits-1:0] bin_index_o;
  logic last_bin_o;
  int pending, fails;
  int sent;
  bit quiet;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  radix2_complex_fft DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i, .start, .busy,
    .sample_real_i, .sample_imag_i, .bin_valid_o, .bin_real_o, .bin_imag_o,
    .bin_index_o, .last_bin_o
  );

  radix2_complex_fft_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i, .start_i(start),
    .busy_i(busy), .sample_real_i, .sample_imag_i, .bin_valid_i(bin_valid_o),
    .bin_real_i(bin_real_o), .bin_imag_i(bin_imag_o), .bin_index_i(bin_index_o),
    .last_bin_i(last_bin_o), .pending_o(pending), .fails_o(fails)
  );

  // Busy only moves on a rising edge, so its value at the falling edge
  // tells whether the next rising edge takes the transfer. Entered and left
  // at a falling edge; start stays high for a following transfer.
  task automatic push_sample(input logic signed [15:0] re, input logic signed [15:0] im);
    if (!quiet) begin
      while ($urandom_range(99) < 11) begin
        start <= 1'b0;
        @(negedge clk_i);
      end
    end
    start <= 1'b1;
    sample_real_i <= re;
    sample_imag_i <= im;
    #1;
    while (busy) @(negedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    wait (pending == 0);
    repeat (40) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [2:0] val);
    settle();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_frame(input int n, input int kind);
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: push_sample(pick_value(), pick_value());
        1: push_sample(16'sh7fff, 16'sh7fff);
        default: push_sample(16'sh8000, 16'sh8000);
      endcase
    end
  endtask

  initial begin
    int lg;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Shortest frames at the extremes, both directions.
    write_reg(CFG_LOG2_POINTS, 3'd1);
    push_sample(16'sh7fff, 16'sh8000);
    push_sample(16'sh8000, 16'sh7fff);
    write_reg(CFG_INVERSE, 3'd1);
    push_sample(16'sh7fff, 16'sh7fff);
    push_sample(16'sh8000, 16'sh8000);
    // A length code of zero behaves as two points.
    write_reg(CFG_LOG2_POINTS, 3'd0);
    push_frame(2, 0);
    write_reg(CFG_INVERSE, 3'd0);
    write_reg(CFG_LOG2_POINTS, 3'd2);
    push_frame(4, 1);
    // A partly loaded frame is dropped by the next register write.
    push_frame(3, 0);
    write_reg(CFG_LOG2_POINTS, 3'd3);
    push_frame(8, 0);
    // A length code of seven behaves as 64 points, here with full-scale input.
    write_reg(CFG_LOG2_POINTS, 3'd7);
    push_frame(64, 1);
    write_reg(CFG_INVERSE, 3'd1);
    write_reg(CFG_LOG2_POINTS, 3'd6);
    push_frame(64, 2);

    while (sent < 300) begin
      quiet = (sent > 180 && sent < 250);
      case ($urandom_range(9))
        0: lg = 0;
        1: lg = 7;
        2: lg = 5;
        3: lg = 6;
        default: lg = $urandom_range(4, 1);
      endcase
      write_reg(CFG_INVERSE, 3'($urandom_range(1)));
      write_reg(CFG_LOG2_POINTS, 3'(lg));
      if (lg == 0) lg = 1;
      if (lg == 7) lg = 6;
      for (int f = $urandom_range(2, 1); f > 0; f--)
        push_frame(1 << lg, ($urandom_range(19) == 0) ? 1 + $urandom_range(1) : 0);
      if ($urandom_range(4) == 0) push_frame($urandom_range((1 << lg) - 1, 1), 0);
    end

    settle();
    repeat (100) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/r2fft_pkg.sv
hw/rtl/r2fft_ram.sv
hw/rtl/radix2_complex_fft.sv
bench/radix2_complex_fft_checker.sv
bench/radix2_complex_fft_tb.sv
